// ===== sv/rotated_frame_cursor_overlay_macros.svh =====
// ----------------------------------------------------------------------------
// rotated frame cursor overlay assertion macros
// shared property forms for the overlay checks
// ----------------------------------------------------------------------------
`ifndef ROTATED_FRAME_CURSOR_OVERLAY_MACROS_SVH
`define ROTATED_FRAME_CURSOR_OVERLAY_MACROS_SVH

// same-cycle implication
`define RFCO_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define RFCO_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/rfco_pkg.sv =====
// ----------------------------------------------------------------------------
// rfco_pkg
// types and codes shared by the cursor overlay files
// ----------------------------------------------------------------------------
package rfco_pkg;

    localparam int FRAME_MAX_SIDE = 8192;
    localparam int COORD_W        = $clog2(FRAME_MAX_SIDE);

    typedef logic [1:0] func_t;
    localparam func_t FUNC_LOAD  = 2'd0;
    localparam func_t FUNC_MAP   = 2'd1;
    localparam func_t FUNC_BLEND = 2'd2;

    typedef logic [1:0] mode_t;
    localparam mode_t MODE_HIDDEN = 2'd0;
    localparam mode_t MODE_MONO   = 2'd1;
    localparam mode_t MODE_ALPHA  = 2'd2;
    localparam mode_t MODE_MASKED = 2'd3;

    typedef logic [1:0] rot_t;
    localparam rot_t ROT_0   = 2'd0;
    localparam rot_t ROT_90  = 2'd1;
    localparam rot_t ROT_180 = 2'd2;
    localparam rot_t ROT_270 = 2'd3;

    typedef logic [2:0]  cfg_index_t;
    typedef logic [13:0] cfg_data_t;
    localparam cfg_index_t REG_ROTATION      = 3'd0;
    localparam cfg_index_t REG_SOURCE_WIDTH  = 3'd1;
    localparam cfg_index_t REG_SOURCE_HEIGHT = 3'd2;
    localparam cfg_index_t REG_CURSOR_LEFT   = 3'd3;
    localparam cfg_index_t REG_CURSOR_TOP    = 3'd4;
    localparam cfg_index_t REG_CURSOR_COLS   = 3'd5;
    localparam cfg_index_t REG_CURSOR_ROWS   = 3'd6;
    localparam cfg_index_t REG_CURSOR_MODE   = 3'd7;

    typedef struct packed {
        func_t              func;
        logic [COORD_W-1:0] pos_x;
        logic [COORD_W-1:0] pos_y;
        logic [7:0]         pixel_b;
        logic [7:0]         pixel_g;
        logic [7:0]         pixel_r;
        logic [7:0]         pixel_a;
    } in_item_t;

    typedef struct packed {
        logic [COORD_W-1:0] src_x;
        logic [COORD_W-1:0] src_y;
        logic [7:0]         out_r;
        logic [7:0]         out_g;
        logic [7:0]         out_b;
        logic               cursor_hit;
    } out_item_t;

endpackage

// ===== sv/rfco_pixel_if.sv =====
// ----------------------------------------------------------------------------
// rfco_pixel_if
// input channel: valid/ready handshake with one work item per transaction
// ----------------------------------------------------------------------------
interface rfco_pixel_if;
    import rfco_pkg::*;

    logic     valid;
    logic     ready;
    in_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== sv/rfco_result_if.sv =====
// ----------------------------------------------------------------------------
// rfco_result_if
// output channel: valid/ready handshake with one result per transaction
// ----------------------------------------------------------------------------
interface rfco_result_if;
    import rfco_pkg::*;

    logic      valid;
    logic      ready;
    out_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== sv/rfco_ram.sv =====
// ----------------------------------------------------------------------------
// rfco_ram
// single-port synchronous ram, registered read that holds without a read
// ----------------------------------------------------------------------------
module rfco_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic                                   re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
    input  logic [WIDTH-1:0]                       wdata,
    output logic [WIDTH-1:0]                       rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[addr];
        end
    end
endmodule

// ===== sv/rotated_frame_cursor_overlay.sv =====
// ----------------------------------------------------------------------------
// rotated_frame_cursor_overlay
// pipeline: each accepted transaction moves through s1_reg, s2_reg, out_reg
// throughput: one transaction per cycle unless the output stalls, bound by the
//   single cursor store port, at most once per item (load writes, blend reads)
// reset: config and pipeline valids return to reset values at once; the cursor
//   store is not cleared and holds unknown data until loaded
// ----------------------------------------------------------------------------
module rotated_frame_cursor_overlay #(
    parameter int CURSOR_MAX_COLS = 64,
    parameter int CURSOR_MAX_ROWS = 64
) (
    input  logic                  clk,
    input  logic                  rst_n,
    rfco_pixel_if.sink            pixel,
    rfco_result_if.source         result,
    input  logic                  cfg_we,
    input  rfco_pkg::cfg_index_t  cfg_index,
    input  rfco_pkg::cfg_data_t   cfg_data
);
    import rfco_pkg::*;

    `include "rotated_frame_cursor_overlay_macros.svh"

    localparam int DEPTH = CURSOR_MAX_COLS * CURSOR_MAX_ROWS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    typedef struct packed {
        func_t              func;
        logic               hit;
        logic [COORD_W-1:0] sx;
        logic [COORD_W-1:0] sy;
        logic [7:0]         dr;
        logic [7:0]         dg;
        logic [7:0]         db;
    } s1_t;

    typedef struct packed {
        func_t              func;
        logic               hit;
        logic [COORD_W-1:0] sx;
        logic [COORD_W-1:0] sy;
        logic [7:0]         dr;
        logic [7:0]         dg;
        logic [7:0]         db;
        logic [7:0]         cr;
        logic [7:0]         cg;
        logic [7:0]         cb;
        logic [7:0]         ca;
        logic [15:0]        mr;
        logic [15:0]        mg;
        logic [15:0]        mb;
    } s2_t;

    // c*a + d*(255-a) + 127, rewritten to use one product
    function automatic logic [15:0] mix_sum(input logic [7:0] c, input logic [7:0] d,
                                            input logic [7:0] a);
        logic signed [8:0]  diff;
        logic signed [17:0] prod;
        logic signed [17:0] total;
        diff  = $signed({1'b0, c}) - $signed({1'b0, d});
        prod  = 18'(diff) * 18'($signed({1'b0, a}));
        total = prod + $signed({2'b00, d, 8'h00}) - $signed({10'd0, d}) + 18'sd127;
        return total[15:0];
    endfunction

    // exact floor(x / 255) for 16-bit x below 65280
    function automatic logic [7:0] div255(input logic [15:0] x);
        logic [16:0] t;
        t = 17'(x) + 17'(x[15:8]) + 17'd1;
        return t[15:8];
    endfunction

    logic [1:0]         rotation_reg;
    logic [13:0]        source_width_reg;
    logic [13:0]        source_height_reg;
    logic signed [13:0] cursor_left_reg;
    logic signed [13:0] cursor_top_reg;
    logic [6:0]         cursor_cols_reg;
    logic [6:0]         cursor_rows_reg;
    mode_t              cursor_mode_reg;

    logic      s1_valid_reg;
    logic      s1_valid_next;
    s1_t       s1_reg;
    s1_t       s1_next;
    logic      s2_valid_reg;
    logic      s2_valid_next;
    s2_t       s2_reg;
    s2_t       s2_next;
    logic      out_valid_reg;
    logic      out_valid_next;
    out_item_t out_reg;
    out_item_t out_next;

    logic      out_adv;
    logic      s2_adv;
    logic      s1_adv;
    logic      in_acc;

    logic signed [14:0] cx;
    logic signed [14:0] cy;
    logic [8:0]         wlim;
    logic [8:0]         hlim;
    logic               hit;
    logic               ld_ok;
    logic [AW-1:0]      ld_addr;
    logic [AW-1:0]      rd_addr;
    logic [AW-1:0]      ram_addr;
    logic               ram_we;
    logic               ram_re;
    logic [31:0]        ram_wdata;
    logic [31:0]        ram_rdata;

    // config
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rotation_reg      <= ROT_0;
            source_width_reg  <= 14'd1;
            source_height_reg <= 14'd1;
            cursor_left_reg   <= '0;
            cursor_top_reg    <= '0;
            cursor_cols_reg   <= '0;
            cursor_rows_reg   <= '0;
            cursor_mode_reg   <= MODE_HIDDEN;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_ROTATION:      rotation_reg      <= cfg_data[1:0];
                REG_SOURCE_WIDTH:  source_width_reg  <= cfg_data;
                REG_SOURCE_HEIGHT: source_height_reg <= cfg_data;
                REG_CURSOR_LEFT:   cursor_left_reg   <= $signed(cfg_data);
                REG_CURSOR_TOP:    cursor_top_reg    <= $signed(cfg_data);
                REG_CURSOR_COLS:   cursor_cols_reg   <= cfg_data[6:0];
                REG_CURSOR_ROWS:   cursor_rows_reg   <= cfg_data[6:0];
                REG_CURSOR_MODE:   cursor_mode_reg   <= cfg_data[1:0];
                default:           cursor_mode_reg   <= cursor_mode_reg;
            endcase
        end
    end

    // flow control
    assign out_adv     = !out_valid_reg || result.ready;
    assign s2_adv      = !s2_valid_reg || out_adv;
    assign s1_adv      = !s1_valid_reg || s2_adv;
    assign pixel.ready = s1_adv;
    assign in_acc      = pixel.valid && s1_adv;

    // stage 0: hit test, coordinate map, store access
    always_comb
    begin
        cx   = $signed({2'b00, pixel.data.pos_x}) - $signed({cursor_left_reg[13], cursor_left_reg});
        cy   = $signed({2'b00, pixel.data.pos_y}) - $signed({cursor_top_reg[13], cursor_top_reg});
        wlim = (9'(cursor_cols_reg) < 9'(CURSOR_MAX_COLS)) ? 9'(cursor_cols_reg)
                                                          : 9'(CURSOR_MAX_COLS);
        hlim = (9'(cursor_rows_reg) < 9'(CURSOR_MAX_ROWS)) ? 9'(cursor_rows_reg)
                                                          : 9'(CURSOR_MAX_ROWS);
        hit  = (cursor_mode_reg != MODE_HIDDEN) && !cx[14] && !cy[14]
               && (cx[13:0] < 14'(wlim)) && (cy[13:0] < 14'(hlim));

        ld_ok   = (pixel.data.pos_x < COORD_W'(CURSOR_MAX_COLS))
                  && (pixel.data.pos_y < COORD_W'(CURSOR_MAX_ROWS));
        ld_addr = AW'(18'(pixel.data.pos_y[8:0]) * 18'(CURSOR_MAX_COLS)
                      + 18'(pixel.data.pos_x[8:0]));
        rd_addr = AW'(18'(cy[8:0]) * 18'(CURSOR_MAX_COLS) + 18'(cx[8:0]));

        if (cursor_mode_reg == MODE_MONO)
        begin
            ram_wdata = {16'h0000, {8{pixel.data.pixel_g[0]}}, {8{pixel.data.pixel_b[0]}}};
        end
        else
        begin
            ram_wdata = {pixel.data.pixel_a, pixel.data.pixel_b,
                         pixel.data.pixel_g, pixel.data.pixel_r};
        end

        ram_we   = in_acc && (pixel.data.func == FUNC_LOAD) && ld_ok;
        ram_re   = in_acc && (pixel.data.func == FUNC_BLEND) && hit;
        ram_addr = (pixel.data.func == FUNC_LOAD) ? ld_addr : rd_addr;

        s1_next.func = pixel.data.func;
        s1_next.hit  = hit;
        s1_next.dr   = pixel.data.pixel_r;
        s1_next.dg   = pixel.data.pixel_g;
        s1_next.db   = pixel.data.pixel_b;
        case (rotation_reg)
            ROT_90:
            begin
                s1_next.sx = source_width_reg[COORD_W-1:0] - COORD_W'(1) - pixel.data.pos_y;
                s1_next.sy = pixel.data.pos_x;
            end
            ROT_180:
            begin
                s1_next.sx = source_width_reg[COORD_W-1:0] - COORD_W'(1) - pixel.data.pos_x;
                s1_next.sy = source_height_reg[COORD_W-1:0] - COORD_W'(1) - pixel.data.pos_y;
            end
            ROT_270:
            begin
                s1_next.sx = pixel.data.pos_y;
                s1_next.sy = source_height_reg[COORD_W-1:0] - COORD_W'(1) - pixel.data.pos_x;
            end
            default:
            begin
                s1_next.sx = pixel.data.pos_x;
                s1_next.sy = pixel.data.pos_y;
            end
        endcase
        s1_valid_next = s1_adv ? pixel.valid : s1_valid_reg;
    end

    rfco_ram #(
        .WIDTH (32),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .re    (ram_re),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    // stage 1: cursor word arrives, alpha products
    always_comb
    begin
        s2_next.func = s1_reg.func;
        s2_next.hit  = s1_reg.hit;
        s2_next.sx   = s1_reg.sx;
        s2_next.sy   = s1_reg.sy;
        s2_next.dr   = s1_reg.dr;
        s2_next.dg   = s1_reg.dg;
        s2_next.db   = s1_reg.db;
        s2_next.cr   = ram_rdata[7:0];
        s2_next.cg   = ram_rdata[15:8];
        s2_next.cb   = ram_rdata[23:16];
        s2_next.ca   = ram_rdata[31:24];
        s2_next.mr   = mix_sum(ram_rdata[7:0], s1_reg.dr, ram_rdata[31:24]);
        s2_next.mg   = mix_sum(ram_rdata[15:8], s1_reg.dg, ram_rdata[31:24]);
        s2_next.mb   = mix_sum(ram_rdata[23:16], s1_reg.db, ram_rdata[31:24]);
        s2_valid_next = s2_adv ? s1_valid_reg : s2_valid_reg;
    end

    // stage 2: compositing rule and result formatting
    always_comb
    begin
        out_next = '0;
        case (s2_reg.func)
            FUNC_MAP:
            begin
                out_next.src_x = s2_reg.sx;
                out_next.src_y = s2_reg.sy;
            end
            FUNC_BLEND:
            begin
                out_next.out_r      = s2_reg.dr;
                out_next.out_g      = s2_reg.dg;
                out_next.out_b      = s2_reg.db;
                out_next.cursor_hit = s2_reg.hit;
                if (s2_reg.hit)
                begin
                    case (cursor_mode_reg)
                        MODE_MONO:
                        begin
                            out_next.out_r = (s2_reg.dr & s2_reg.cr) ^ s2_reg.cg;
                            out_next.out_g = (s2_reg.dg & s2_reg.cr) ^ s2_reg.cg;
                            out_next.out_b = (s2_reg.db & s2_reg.cr) ^ s2_reg.cg;
                        end
                        MODE_ALPHA:
                        begin
                            out_next.out_r = div255(s2_reg.mr);
                            out_next.out_g = div255(s2_reg.mg);
                            out_next.out_b = div255(s2_reg.mb);
                        end
                        MODE_MASKED:
                        begin
                            if (s2_reg.ca == 8'h00)
                            begin
                                out_next.out_r = s2_reg.cr;
                                out_next.out_g = s2_reg.cg;
                                out_next.out_b = s2_reg.cb;
                            end
                            else
                            begin
                                out_next.out_r = s2_reg.dr ^ s2_reg.cr;
                                out_next.out_g = s2_reg.dg ^ s2_reg.cg;
                                out_next.out_b = s2_reg.db ^ s2_reg.cb;
                            end
                        end
                        default:
                        begin
                            out_next.out_r = s2_reg.dr;
                        end
                    endcase
                end
            end
            default:
            begin
                out_next = '0;
            end
        endcase
        out_valid_next = out_adv ? s2_valid_reg : out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            s2_valid_reg  <= s2_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            s1_reg <= s1_next;
        end
        if (s2_adv && s1_valid_reg)
        begin
            s2_reg <= s2_next;
        end
        if (out_adv && s2_valid_reg)
        begin
            out_reg <= out_next;
        end
    end

    assign result.valid = out_valid_reg;
    assign result.data  = out_reg;

    `RFCO_ASSERT_NEXT(a_accept_fills_s1, clk, rst_n, pixel.valid && pixel.ready,
        s1_valid_reg, "accepted transaction did not reach stage 1")
    `RFCO_ASSERT_NEXT(a_s2_held_on_stall, clk, rst_n, s2_valid_reg && !out_adv,
        s2_valid_reg && $stable(s2_reg), "stage 2 lost or changed while stalled")
    `RFCO_ASSERT_NEXT(a_store_data_held, clk, rst_n, s1_valid_reg && !s2_adv,
        $stable(ram_rdata), "cursor word changed under a stalled stage 1")
endmodule
